[sv/fpr_pkg.sv]
// Package for the field position block: payload structs, configuration
// register codes, reset values and the cosine table. No dependencies.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int unsigned TILT_LIMIT_DEG_DEF = 60;
  localparam int unsigned FRAC_BITS_DEF      = 4;

  localparam int unsigned CFG_DW    = 10;
  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  localparam logic [9:0] FIELD_WIDTH_RST  = 10'd182;
  localparam logic [9:0] FIELD_LENGTH_RST = 10'd243;

  localparam int unsigned FULL_TURN_DEG = 360;
  localparam int unsigned HALF_TURN_DEG = 180;
  localparam int unsigned STOP_LO_DEG   = 60;
  localparam int unsigned STOP_HI_DEG   = 300;
  localparam int unsigned CENTER_LO_CM  = 60;
  localparam int unsigned CENTER_HI_CM  = 122;
  localparam int unsigned BOOST_CM      = 20;

  localparam logic [14:0] COS_ONE = 15'd16384;
  localparam int unsigned COS_ENTRIES = 91;
  localparam logic [63:0] RAD_PER_DEG_Q30 = 64'd18740330;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FRONT_OFS = 3'd0,
    CFG_BACK_OFS  = 3'd1,
    CFG_LEFT_OFS  = 3'd2,
    CFG_RIGHT_OFS = 3'd3,
    CFG_FIELD_WID = 3'd4,
    CFG_FIELD_LEN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0] range_front;
    logic [9:0] range_back;
    logic [9:0] range_left;
    logic [9:0] range_right;
    logic [8:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic        reading_valid;
    logic        stop_drive;
  } out_item_t;

  typedef struct packed {
    logic signed [7:0] front_ofs;
    logic signed [7:0] back_ofs;
    logic signed [7:0] left_ofs;
    logic signed [7:0] right_ofs;
    logic [9:0]        field_width;
    logic [9:0]        field_length;
  } cfg_t;

  // classified item between front and back; distances in signed cm
  typedef struct packed {
    logic signed [11:0] a_front;
    logic signed [11:0] a_back;
    logic signed [11:0] a_left;
    logic signed [11:0] a_right;
    logic               tilt;
    logic [14:0]        cos_q14;
    logic               stop;
  } mid_item_t;

  typedef logic [0:COS_ENTRIES-1][14:0] cos_tab_t;

  // cos(d deg) in Q14 from an eleven-term series in Q30, evaluated at elaboration
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    int                 d;
    int                 k;
    for (d = 0; d < COS_ENTRIES; d++) begin
      x    = 64'(d) * RAD_PER_DEG_Q30;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (k = 1; k <= 10; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k - 1) * (2 * k));
        if ((k % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      rnd    = (unsigned'(sum) + (64'd1 << 15)) >> 16;
      tab[d] = rnd[14:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

[sv/field_position_from_ranges.sv]
// Top level of the field position block: configuration registers, front,
// middle queue, back and result queue. Depends on fpr_pkg, fpr_fifo,
// fpr_front and fpr_back.
`timescale 1ns / 1ps

// Takes one item per clock while full is low and returns one result item per item,
// in order. An accepted item is classified on entry (heading fold, cosine pick,
// offsets) and stored in a two-entry queue; the back end multiplies by the
// cosine in one stage and then forms, clamps and stores the position into a
// two-entry result queue, from which it shows on the result ports. The
// sustained rate is one item per cycle, set by the single multiply stage, as
// long as pop keeps up. Configuration writes take effect on the next edge and
// are meant for times with no item in flight.
module field_position_from_ranges #(
  parameter int unsigned TILT_LIMIT_DEG = fpr_pkg::TILT_LIMIT_DEG_DEF,
  parameter int unsigned FRAC_BITS      = fpr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  fpr_pkg::in_item_t           in_item_i,
  output logic                        empty,
  input  logic                        pop,
  output fpr_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [fpr_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [fpr_pkg::CFG_DW-1:0]  cfg_data_i
);

  fpr_pkg::cfg_t      cfg_q, cfg_d;
  fpr_pkg::mid_item_t mid_in, mid_out;
  fpr_pkg::out_item_t back_out;
  logic               mid_empty, mid_pop;
  logic               out_full, out_push;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (fpr_pkg::cfg_idx_e'(cfg_idx_i))
        fpr_pkg::CFG_FRONT_OFS: cfg_d.front_ofs    = signed'(cfg_data_i[7:0]);
        fpr_pkg::CFG_BACK_OFS:  cfg_d.back_ofs     = signed'(cfg_data_i[7:0]);
        fpr_pkg::CFG_LEFT_OFS:  cfg_d.left_ofs     = signed'(cfg_data_i[7:0]);
        fpr_pkg::CFG_RIGHT_OFS: cfg_d.right_ofs    = signed'(cfg_data_i[7:0]);
        fpr_pkg::CFG_FIELD_WID: cfg_d.field_width  = cfg_data_i[9:0];
        fpr_pkg::CFG_FIELD_LEN: cfg_d.field_length = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_ofs    <= '0;
      cfg_q.back_ofs     <= '0;
      cfg_q.left_ofs     <= '0;
      cfg_q.right_ofs    <= '0;
      cfg_q.field_width  <= fpr_pkg::FIELD_WIDTH_RST;
      cfg_q.field_length <= fpr_pkg::FIELD_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fpr_front #(
    .TILT_LIMIT_DEG(TILT_LIMIT_DEG)
  ) u_front (
    .item_i(in_item_i),
    .cfg_i (cfg_q),
    .mid_o (mid_in)
  );

  fpr_fifo #(
    .T    (fpr_pkg::mid_item_t),
    .DEPTH(fpr_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (mid_in),
    .full_o (full),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .empty_o(mid_empty)
  );

  fpr_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mid_i         (mid_out),
    .mid_empty_i   (mid_empty),
    .mid_pop_o     (mid_pop),
    .field_width_i (cfg_q.field_width),
    .field_length_i(cfg_q.field_length),
    .out_full_i    (out_full),
    .out_push_o    (out_push),
    .out_o         (back_out)
  );

  fpr_fifo #(
    .T    (fpr_pkg::out_item_t),
    .DEPTH(fpr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_out),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

  a_out_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  a_mid_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back end took from empty queue");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("queues not empty after reset");

endmodule

[sv/fpr_fifo.sv]
// Small synchronous queue of any packed type, used between front and back
// and on the result side. No package dependency.
`timescale 1ns / 1ps

module fpr_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/fpr_front.sv]
// Front end: wraps and folds the heading, picks the cosine, sets the stop
// flag, applies the sensor offsets. Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_front #(
  parameter int unsigned TILT_LIMIT_DEG = fpr_pkg::TILT_LIMIT_DEG_DEF
) (
  input  fpr_pkg::in_item_t  item_i,
  input  fpr_pkg::cfg_t      cfg_i,
  output fpr_pkg::mid_item_t mid_o
);

  logic [8:0] wrap;
  logic [8:0] fold9;
  logic [7:0] fold;
  logic       tilt;

  function automatic logic signed [11:0] add_ofs(logic [9:0] r, logic signed [7:0] ofs);
    return signed'({2'b00, r}) + 12'(ofs);
  endfunction

  always_comb begin
    wrap  = (item_i.heading >= 9'(fpr_pkg::FULL_TURN_DEG))
          ? item_i.heading - 9'(fpr_pkg::FULL_TURN_DEG) : item_i.heading;
    fold9 = (wrap > 9'(fpr_pkg::HALF_TURN_DEG)) ? 9'(fpr_pkg::FULL_TURN_DEG) - wrap : wrap;
    fold  = fold9[7:0];
    tilt  = (fold < 8'(TILT_LIMIT_DEG));

    mid_o.a_front = add_ofs(item_i.range_front, cfg_i.front_ofs);
    mid_o.a_back  = add_ofs(item_i.range_back,  cfg_i.back_ofs);
    mid_o.a_left  = add_ofs(item_i.range_left,  cfg_i.left_ofs);
    mid_o.a_right = add_ofs(item_i.range_right, cfg_i.right_ofs);
    mid_o.tilt    = tilt;
    mid_o.cos_q14 = tilt ? fpr_pkg::COS_TAB[fold[6:0]] : fpr_pkg::COS_ONE;
    mid_o.stop    = !((wrap < 9'(fpr_pkg::STOP_LO_DEG)) || (wrap > 9'(fpr_pkg::STOP_HI_DEG)));
  end

endmodule

[sv/fpr_back.sv]
// Back end: tilt correction multipliers in one stage, then sign test,
// position sums, clamp and held-position update. Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_back #(
  parameter int unsigned FRAC_BITS = fpr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpr_pkg::mid_item_t mid_i,
  input  logic               mid_empty_i,
  output logic               mid_pop_o,
  input  logic [9:0]         field_width_i,
  input  logic [9:0]         field_length_i,
  input  logic               out_full_i,
  output logic               out_push_o,
  output fpr_pkg::out_item_t out_o
);

  localparam int unsigned CW = 12 + FRAC_BITS;
  localparam int unsigned SW = 15 + FRAC_BITS;
  localparam int unsigned MW = 27 + FRAC_BITS;
  localparam logic signed [SW-1:0] X_LO  = SW'((2 * fpr_pkg::CENTER_LO_CM) << FRAC_BITS);
  localparam logic signed [SW-1:0] X_HI  = SW'((2 * fpr_pkg::CENTER_HI_CM) << FRAC_BITS);
  localparam logic signed [SW-1:0] BOOST = SW'(fpr_pkg::BOOST_CM << FRAC_BITS);

  function automatic logic signed [CW-1:0] correct(logic signed [11:0] a, logic tilt,
                                                   logic [14:0] c);
    logic [10:0]          mag;
    logic [25:0]          prod;
    logic [MW-1:0]        rnd;
    logic signed [CW-1:0] p;
    mag  = a[11] ? 11'(-a) : 11'(a);
    prod = 26'(mag) * 26'(c);
    rnd  = (MW'(prod) << FRAC_BITS) + MW'(1 << 13);
    p    = signed'(CW'(rnd >> 14));
    if (!tilt) begin
      return CW'(a) <<< FRAC_BITS;
    end
    return a[11] ? -p : p;
  endfunction

  function automatic logic [13:0] clamp(logic signed [SW-1:0] v, logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

  logic                 s1_v_q, s1_v_d;
  logic signed [CW-1:0] f_q, b_q, l_q, r_q;
  logic                 stop_q;
  logic [13:0]          held_x_q, held_y_q;

  logic signed [SW-1:0] wmax, lmax, sx, sy, fb, bb, hx, hy;
  logic                 zero, odd_neg, valid, center;

  assign mid_pop_o  = !mid_empty_i && (!s1_v_q || !out_full_i);
  assign out_push_o = s1_v_q && !out_full_i;

  always_comb begin
    s1_v_d = s1_v_q;
    if (mid_pop_o) begin
      s1_v_d = 1'b1;
    end else if (out_push_o) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      f_q    <= correct(mid_i.a_front, mid_i.tilt, mid_i.cos_q14);
      b_q    <= correct(mid_i.a_back,  mid_i.tilt, mid_i.cos_q14);
      l_q    <= correct(mid_i.a_left,  mid_i.tilt, mid_i.cos_q14);
      r_q    <= correct(mid_i.a_right, mid_i.tilt, mid_i.cos_q14);
      stop_q <= mid_i.stop;
    end
  end

  always_comb begin
    wmax    = signed'(SW'(field_width_i))  <<< FRAC_BITS;
    lmax    = signed'(SW'(field_length_i)) <<< FRAC_BITS;
    zero    = (f_q == 0) || (b_q == 0) || (l_q == 0) || (r_q == 0);
    odd_neg = f_q[CW-1] ^ b_q[CW-1] ^ l_q[CW-1] ^ r_q[CW-1];
    valid   = zero || !odd_neg;
    sx      = SW'(l_q) + wmax - SW'(r_q);
    center  = (sx >= X_LO) && (sx <= X_HI);
    fb      = center ? SW'(f_q) + BOOST : SW'(f_q);
    bb      = center ? SW'(b_q) + BOOST : SW'(b_q);
    sy      = bb + lmax - fb;
    hx      = valid ? (sx >>> 1) : signed'(SW'(held_x_q));
    hy      = valid ? (sy >>> 1) : signed'(SW'(held_y_q));
    out_o.pos_x         = clamp(hx, wmax);
    out_o.pos_y         = clamp(hy, lmax);
    out_o.reading_valid = valid;
    out_o.stop_drive    = stop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
    end else if (out_push_o) begin
      held_x_q <= out_o.pos_x;
      held_y_q <= out_o.pos_y;
    end
  end

endmodule

[verif/field_position_from_ranges_test.sv]
// Testbench for field_position_from_ranges: a directed table and random items,
// each result checked against a typed value or a local field position predictor.
// Depends on fpr_pkg and the field_position_from_ranges RTL.
`timescale 1ns / 1ps

module field_position_from_ranges_test;
  import fpr_pkg::*;

  localparam int     FRAC      = FRAC_BITS_DEF;
  localparam int     TILT_DEG  = TILT_LIMIT_DEG_DEF;
  localparam longint CM        = longint'(1) << FRAC;
  localparam longint NEAR_LO   = 2 * longint'(CENTER_LO_CM) * CM;
  localparam longint NEAR_HI   = 2 * longint'(CENTER_HI_CM) * CM;
  localparam longint BOOST     = longint'(BOOST_CM) * CM;
  localparam int     TURN      = int'(FULL_TURN_DEG);
  localparam int     HALF      = int'(HALF_TURN_DEG);
  localparam int     STOP_LO   = int'(STOP_LO_DEG);
  localparam int     STOP_HI   = int'(STOP_HI_DEG);
  localparam int     RANGE_MAX = 1023;
  localparam int     WATCHDOG  = 4000;
  localparam int     HOLD_AT   = 230;
  localparam int     HOLD_LEN  = 300;
  localparam int     PHASES    = 5;
  localparam int     PER_PHASE = 95;
  localparam int     SHOW_MAX  = 10;
  localparam int     HEAD_MARKS [6] = '{0, 60, 180, 300, 360, 420};

  typedef enum logic [1:0] {
    ROW_SETUP,
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_t      setup;
    in_item_t  item;
    out_item_t want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  in_item_t          item_in;
  logic              empty;
  logic              pop;
  out_item_t         item_out;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  cfg_t        cur_cfg;
  logic [13:0] held_x;
  logic [13:0] held_y;
  longint      cos_q14 [0:90];
  out_item_t   pending_positions [$];
  int          fails;
  int          shown;
  int          results_seen;

  field_position_from_ranges u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (item_in),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (item_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic in_item_t mk_item(int f, int b, int l, int r, int h);
    in_item_t it;
    it.range_front = 10'(f);
    it.range_back  = 10'(b);
    it.range_left  = 10'(l);
    it.range_right = 10'(r);
    it.heading     = 9'(h);
    return it;
  endfunction

  function automatic dir_row_t item_row(int f, int b, int l, int r, int h);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_PREDICT;
    row.item = mk_item(f, b, l, r, h);
    return row;
  endfunction

  function automatic dir_row_t typed_row(int f, int b, int l, int r, int h,
                                         int x, int y, bit ok, bit stop);
    dir_row_t row;
    row                    = '0;
    row.kind               = ROW_TYPED;
    row.item               = mk_item(f, b, l, r, h);
    row.want.pos_x         = 14'(x);
    row.want.pos_y         = 14'(y);
    row.want.reading_valid = ok;
    row.want.stop_drive    = stop;
    return row;
  endfunction

  function automatic dir_row_t setup_row(int fo, int bo, int lo, int ro, int w, int len);
    dir_row_t row;
    row                    = '0;
    row.kind               = ROW_SETUP;
    row.setup.front_ofs    = 8'(fo);
    row.setup.back_ofs     = 8'(bo);
    row.setup.left_ofs     = 8'(lo);
    row.setup.right_ofs    = 8'(ro);
    row.setup.field_width  = 10'(w);
    row.setup.field_length = 10'(len);
    return row;
  endfunction

  dir_row_t dir_tab [$] = '{
    typed_row(0, 0, 0, 0, 0, 1456, 1944, 1'b1, 1'b0),
    typed_row(1023, 1023, 1023, 1023, 180, 1456, 1944, 1'b1, 1'b1),
    typed_row(0, 0, 0, 0, 511, 1456, 1944, 1'b1, 1'b1),
    item_row(1023, 0, 1023, 0, 59),
    item_row(100, 50, 30, 200, 60),
    item_row(200, 40, 100, 90, 300),
    item_row(200, 40, 100, 90, 301),
    item_row(10, 20, 30, 40, 360),
    item_row(10, 20, 30, 40, 420),
    item_row(700, 300, 600, 500, 359),
    item_row(300, 700, 500, 600, 181),
    // x right at the limits of the center band
    item_row(5, 5, 0, 62, 90),
    item_row(5, 5, 0, 63, 90),
    item_row(5, 5, 62, 0, 90),
    item_row(5, 5, 63, 0, 90),
    // empty field, front pulled negative
    setup_row(-128, 0, 0, 0, 0, 0),
    typed_row(0, 5, 5, 5, 90, 0, 0, 1'b0, 1'b1),
    typed_row(128, 5, 5, 5, 90, 0, 0, 1'b1, 1'b1),
    typed_row(1023, 1023, 1023, 1023, 0, 0, 0, 1'b1, 1'b0),
    typed_row(0, 0, 0, 0, 300, 0, 0, 1'b1, 1'b1),
    setup_row(127, -128, -1, 1, 1023, 1023),
    item_row(0, 0, 0, 0, 30),
    item_row(1023, 1023, 1023, 1023, 45),
    item_row(0, 1023, 1, 0, 0),
    item_row(0, 0, 5, 0, 10),
    item_row(5, 5, 5, 5, 59),
    item_row(1023, 0, 0, 1023, 240)
  };

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'($urandom);
      default: return 8'($urandom_range(0, 40) - 20);
    endcase
  endfunction

  function automatic logic [9:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'h3ff;
      3: return 10'($urandom);
      default: return 10'($urandom_range(100, 400));
    endcase
  endfunction

  function automatic logic [9:0] noisy_reading(int v);
    int r;
    r = v + int'($urandom_range(0, 16)) - 8;
    if (r < 0) r = 0;
    if (r > RANGE_MAX) r = RANGE_MAX;
    return 10'(r);
  endfunction

  // zero, full scale, or the reading that cancels a negative offset (else zero)
  function automatic logic [9:0] corner_reading(logic signed [7:0] ofs);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return (ofs < 0) ? 10'(-int'(ofs)) : '0;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] ofs_word(logic signed [7:0] v);
    return {{(CFG_DW - 8){v[7]}}, v};
  endfunction

  function automatic longint corrected(longint a, bit tilt, longint c);
    longint scaled;
    longint mag;
    longint p;
    scaled = a * CM;
    if (!tilt) return scaled;
    mag = (scaled < 0) ? -scaled : scaled;
    p   = (mag * c + (longint'(1) << 13)) >>> 14;
    return (scaled < 0) ? -p : p;
  endfunction

  function automatic longint fit(longint v, longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic out_item_t next_position(in_item_t it);
    int        head;
    int        fold;
    int        negs;
    bit        tilt;
    bit        ok;
    longint    c;
    longint    f;
    longint    b;
    longint    l;
    longint    r;
    longint    wmax;
    longint    lmax;
    longint    sx;
    longint    hx;
    longint    hy;
    out_item_t res;
    head = int'(it.heading);
    if (head >= TURN) head -= TURN;
    fold = (head > HALF) ? TURN - head : head;
    tilt = fold < TILT_DEG;
    c    = tilt ? cos_q14[fold] : longint'(COS_ONE);
    f = corrected(longint'(it.range_front) + longint'(signed'(cur_cfg.front_ofs)), tilt, c);
    b = corrected(longint'(it.range_back) + longint'(signed'(cur_cfg.back_ofs)), tilt, c);
    l = corrected(longint'(it.range_left) + longint'(signed'(cur_cfg.left_ofs)), tilt, c);
    r = corrected(longint'(it.range_right) + longint'(signed'(cur_cfg.right_ofs)), tilt, c);
    wmax = longint'(cur_cfg.field_width) * CM;
    lmax = longint'(cur_cfg.field_length) * CM;
    negs = int'(f < 0) + int'(b < 0) + int'(l < 0) + int'(r < 0);
    ok   = (f == 0) || (b == 0) || (l == 0) || (r == 0) || (negs % 2 == 0);
    hx   = longint'(held_x);
    hy   = longint'(held_y);
    if (ok) begin
      sx = l + wmax - r;
      hx = sx >>> 1;
      if (sx >= NEAR_LO && sx <= NEAR_HI) begin
        f += BOOST;
        b += BOOST;
      end
      hy = (b + lmax - f) >>> 1;
    end
    held_x            = 14'(fit(hx, wmax));
    held_y            = 14'(fit(hy, lmax));
    res.pos_x         = held_x;
    res.pos_y         = held_y;
    res.reading_valid = ok;
    res.stop_drive    = !(head < STOP_LO || head > STOP_HI);
    return res;
  endfunction

  task automatic offer(input in_item_t it, input bit typed, input out_item_t want,
                       input bit eager);
    int        gap;
    out_item_t calc;
    gap = eager ? 0 : pause_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    item_in <= it;
    do @(posedge clk_i); while (full !== 1'b0);
    calc = next_position(it);
    pending_positions.push_back(typed ? want : calc);
  endtask

  // registers change only with nothing in flight
  task automatic load_setup(input cfg_t s);
    cfg_idx_e idx;
    push <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        CFG_FRONT_OFS: cfg_data <= ofs_word(s.front_ofs);
        CFG_BACK_OFS:  cfg_data <= ofs_word(s.back_ofs);
        CFG_LEFT_OFS:  cfg_data <= ofs_word(s.left_ofs);
        CFG_RIGHT_OFS: cfg_data <= ofs_word(s.right_ofs);
        CFG_FIELD_WID: cfg_data <= s.field_width;
        default:       cfg_data <= s.field_length;
      endcase
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we  <= 1'b0;
    cur_cfg = s;
  endtask

  initial begin : stimulus
    int               p;
    int               n;
    int               d;
    int               k;
    int               px;
    int               py;
    int               w;
    int               lg;
    longint unsigned  ang;
    longint unsigned  ang_sq;
    longint unsigned  term;
    longint           acc;
    cfg_t             s;
    in_item_t         it;
    rst_ni   = 1'b0;
    push     = 1'b0;
    item_in  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    fails    = 0;
    shown    = 0;
    held_x   = '0;
    held_y   = '0;
    cur_cfg              = '0;
    cur_cfg.field_width  = FIELD_WIDTH_RST;
    cur_cfg.field_length = FIELD_LENGTH_RST;
    // cosine in Q14 from an eleven-term series in Q30, truncating each step
    for (d = 0; d <= 90; d++) begin
      ang    = longint'(d) * RAD_PER_DEG_Q30;
      ang_sq = (ang * ang) >> 30;
      term   = longint'(1) << 30;
      acc    = longint'(term);
      for (k = 1; k <= 10; k++) begin
        term = (term * ang_sq) >> 30;
        term = term / longint'((2 * k - 1) * (2 * k));
        acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      cos_q14[d] = (acc + (longint'(1) << 15)) >>> 16;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_SETUP: load_setup(dir_tab[i].setup);
        ROW_TYPED: offer(dir_tab[i].item, 1'b1, dir_tab[i].want, 1'b0);
        default:   offer(dir_tab[i].item, 1'b0, '0, 1'b0);
      endcase
    end

    for (p = 0; p < PHASES; p++) begin
      s.front_ofs    = rand_offset();
      s.back_ofs     = rand_offset();
      s.left_ofs     = rand_offset();
      s.right_ofs    = rand_offset();
      s.field_width  = rand_size();
      s.field_length = rand_size();
      if (p == PHASES - 1) begin
        s              = '0;
        s.field_width  = FIELD_WIDTH_RST;
        s.field_length = FIELD_LENGTH_RST;
      end
      load_setup(s);
      for (n = 0; n < PER_PHASE; n++) begin
        w  = int'(cur_cfg.field_width);
        lg = int'(cur_cfg.field_length);
        px = $urandom_range(0, w);
        py = $urandom_range(0, lg);
        case ($urandom_range(0, 9))
          6, 7: begin
            it.range_front = 10'($urandom);
            it.range_back  = 10'($urandom);
            it.range_left  = 10'($urandom);
            it.range_right = 10'($urandom);
          end
          8: begin
            it.range_front = corner_reading(cur_cfg.front_ofs);
            it.range_back  = corner_reading(cur_cfg.back_ofs);
            it.range_left  = corner_reading(cur_cfg.left_ofs);
            it.range_right = corner_reading(cur_cfg.right_ofs);
          end
          9: begin
            it.range_front = 10'($urandom_range(0, 15));
            it.range_back  = 10'($urandom_range(0, 15));
            it.range_left  = 10'($urandom_range(0, 15));
            it.range_right = 10'($urandom_range(0, 15));
          end
          default: begin
            it.range_left  = noisy_reading(px - int'(cur_cfg.left_ofs));
            it.range_right = noisy_reading(w - px - int'(cur_cfg.right_ofs));
            it.range_back  = noisy_reading(py - int'(cur_cfg.back_ofs));
            it.range_front = noisy_reading(lg - py - int'(cur_cfg.front_ofs));
          end
        endcase
        case ($urandom_range(0, 2))
          0: it.heading = 9'($urandom_range(0, 511));
          1: it.heading = 9'($urandom_range(0, 1) ? $urandom_range(0, 70)
                                                  : $urandom_range(290, 359));
          default: it.heading = 9'(HEAD_MARKS[$urandom_range(0, 5)]
                                   + $urandom_range(0, 2) - 1);
        endcase
        offer(it, 1'b0, '0, p == 1);
      end
    end

    push <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : sink
    int        stall;
    bit        held_once;
    out_item_t want;
    pop          = 1'b0;
    held_once    = 1'b0;
    results_seen = 0;
    @(posedge rst_ni);
    forever begin
      if (results_seen == HOLD_AT && !held_once) begin
        stall     = HOLD_LEN;
        held_once = 1'b1;
      end else begin
        stall = ((results_seen / 64) % 4 == 1) ? 0 : pause_len();
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      results_seen++;
      if (pending_positions.size() == 0) begin
        fails++;
        if (shown < SHOW_MAX) begin
          $display("unexpected result: x=%0d y=%0d valid=%0b stop=%0b", item_out.pos_x,
                   item_out.pos_y, item_out.reading_valid, item_out.stop_drive);
        end
        shown++;
      end else begin
        want = pending_positions.pop_front();
        if (item_out.pos_x !== want.pos_x || item_out.pos_y !== want.pos_y ||
            item_out.reading_valid !== want.reading_valid ||
            item_out.stop_drive !== want.stop_drive) begin
          fails++;
          if (shown < SHOW_MAX) begin
            $display("result %0d (exp/got): x %0d/%0d y %0d/%0d valid %0b/%0b stop %0b/%0b",
                     results_seen, want.pos_x, item_out.pos_x, want.pos_y, item_out.pos_y,
                     want.reading_valid, item_out.reading_valid,
                     want.stop_drive, item_out.stop_drive);
          end
          shown++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk_i);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
